// File: design/deq_pkg.sv
package deq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W = 3;
  localparam int KEY_W = 31;
  localparam int PAY_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_PEEK_FRONT = 3'd3,
    CMD_REVERSE    = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic             en;
    idx_t             addr;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } mem_rd_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  function automatic idx_t ring_prev(idx_t i);
    return (i == '0) ? idx_t'(QUEUE_DEPTH - 1) : idx_t'(i - idx_t'(1));
  endfunction

endpackage

// File: design/deq_if.sv
interface deq_req_if;
  import deq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0] entry_payload;

  modport source (output valid, cmd, entry_key, entry_payload, input ready);
  modport sink   (input valid, cmd, entry_key, entry_payload, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [KEY_W-1:0] front_key;
  logic [PAY_W-1:0] front_payload;
  logic [OCC_W-1:0] occupancy;
  logic             is_empty;

  modport source (output valid, ok, front_key, front_payload, occupancy, is_empty,
                  input ready);
  modport sink   (input valid, ok, front_key, front_payload, occupancy, is_empty,
                  output ready);
endinterface

// File: design/deq_store.sv
module deq_store (
  input  logic                    clk,
  input  deq_pkg::mem_wr_t        wr,
  input  deq_pkg::mem_rd_t        rd,
  output logic [deq_pkg::KEY_W-1:0] rd_key,
  output logic [deq_pkg::PAY_W-1:0] rd_payload
);
  import deq_pkg::*;

  logic [KEY_W+PAY_W-1:0] mem [QUEUE_DEPTH];
  logic [KEY_W+PAY_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.key, wr.payload};
    end
    if (rd.en) begin
      rd_word <= mem[rd.addr];
    end
  end

  assign rd_key     = rd_word[KEY_W+PAY_W-1:PAY_W];
  assign rd_payload = rd_word[PAY_W-1:0];

endmodule

// File: design/double_ended_record_queue_top.sv
// Channel | Dir | Beat contents
// req     | in  | cmd, entry_key, entry_payload
// rsp     | out | ok, front_key, front_payload, occupancy, is_empty
//
// Push, reverse and unknown commands finish in ST_IDLE, as does a pop or peek on an
// empty queue; a pop or peek that finds a record also passes through ST_READ,
// since the record store registers its read data.
// A new command is taken once the previous one has finished and the result
// register is free or being emptied in the same cycle.
// rst (synchronous) empties the queue and clears the direction flag; the
// store itself is not cleared. A stalled rsp holds its beat and blocks req.
module double_ended_record_queue_top (
  input  logic      clk,
  input  logic      rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  state_t state, state_next;
  idx_t   head, head_next;
  idx_t   tail, tail_next;
  cnt_t   count, count_next;
  logic   reversed, reversed_next;

  logic             res_valid, res_valid_next;
  logic             res_ok, res_ok_next;
  logic [KEY_W-1:0] res_key, res_key_next;
  logic [PAY_W-1:0] res_payload, res_payload_next;
  cnt_t             res_count, res_count_next;

  mem_wr_t          wr;
  mem_rd_t          rd;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_payload;

  logic accept;
  logic full;
  logic empty;
  logic at_start;
  idx_t front_slot;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  deq_store u_store (
    .clk        (clk),
    .wr         (wr),
    .rd         (rd),
    .rd_key     (rd_key),
    .rd_payload (rd_payload)
  );

  assign req.ready = (state == ST_IDLE) && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == cnt_t'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign at_start  = (cmd_t'(req.cmd) == CMD_PUSH_FRONT) != reversed;
  assign front_slot = reversed ? ring_prev(tail) : head;

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    reversed_next    = reversed;
    res_valid_next   = res_valid && !rsp.ready;
    res_ok_next      = res_ok;
    res_key_next     = res_key;
    res_payload_next = res_payload;
    res_count_next   = res_count;
    wr.en            = 1'b0;
    wr.addr          = at_start ? ring_prev(head) : tail;
    wr.key           = req.entry_key;
    wr.payload       = req.entry_payload;
    rd.en            = 1'b0;
    rd.addr          = front_slot;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_ok_next      = 1'b0;
          res_key_next     = '0;
          res_payload_next = '0;
          res_valid_next   = 1'b1;
          unique case (req.cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              if (!full) begin
                wr.en       = 1'b1;
                res_ok_next = 1'b1;
                count_next  = cnt_t'(count + cnt_t'(1));
                if (at_start) begin
                  head_next = ring_prev(head);
                end else begin
                  tail_next = ring_next(tail);
                end
              end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
              if (!empty) begin
                // hold the beat until the record arrives from the store
                rd.en          = 1'b1;
                res_ok_next    = 1'b1;
                res_valid_next = 1'b0;
                state_next     = ST_READ;
                if (cmd_t'(req.cmd) == CMD_POP_FRONT) begin
                  count_next = cnt_t'(count - cnt_t'(1));
                  if (reversed) begin
                    tail_next = front_slot;
                  end else begin
                    head_next = ring_next(head);
                  end
                end
              end
            end
            CMD_REVERSE: begin
              reversed_next = !reversed;
              res_ok_next   = 1'b1;
            end
            default: begin
            end
          endcase
          res_count_next = count_next;
        end
      end
      ST_READ: begin
        res_valid_next   = 1'b1;
        res_key_next     = rd_key;
        res_payload_next = rd_payload;
        state_next       = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      reversed  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      reversed  <= reversed_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_ok      <= res_ok_next;
    res_key     <= res_key_next;
    res_payload <= res_payload_next;
    res_count   <= res_count_next;
  end

  assign occ_wide = {{OCC_W{1'b0}}, res_count};

  assign rsp.valid         = res_valid;
  assign rsp.ok            = res_ok;
  assign rsp.front_key     = res_key;
  assign rsp.front_payload = res_payload;
  assign rsp.occupancy     = occ_wide[OCC_W-1:0];
  assign rsp.is_empty      = (res_count == '0);

endmodule
